/* rtl/assert_macros.svh */
// Assertion helpers for the checking modules; the back end includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define HFCC_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("hfcc assertion failed");

// Check a property on every rising edge, reset included.
`define HFCC_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("hfcc assertion failed");

`endif

/* rtl/hfcc_pkg.sv */
package hfcc_pkg;

  localparam logic [15:0] CRC_INIT     = 16'hFFFF;
  localparam logic [15:0] CRC_POLY     = 16'h1021;
  localparam int          MIN_CHARS    = 14;
  localparam int          DELAY_DEPTH  = 5;
  localparam int          HEADER_BYTES = 5;
  localparam logic [3:0]  COUNT_MAX    = 4'd15;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_SHORT    = 2'd1,
    STATUS_MISMATCH = 2'd2
  } status_t;

  typedef struct packed {
    logic [7:0] character;
    logic       last;
  } char_beat_t;

  typedef struct packed {
    status_t     status;
    logic [7:0]  frame_id;
    logic [15:0] sequence_res;
    logic [15:0] payload_length;
    logic [15:0] received_crc;
  } res_beat_t;

  // One unit of work from the front to the back.
  typedef struct packed {
    logic        byte_ok;
    logic [7:0]  byte_val;
    logic        last;
    logic        short_frame;
    logic [15:0] rx_crc;
  } op_t;

  // Digit value in the low four bits; bit 4 set when not a hex digit.
  function automatic logic [4:0] hfcc_hex_digit(input logic [7:0] c);
    logic [4:0] d;
    d = 5'd16;
    if (c >= 8'h30 && c <= 8'h39) d = {1'b0, 4'(c - 8'h30)};
    else if (c >= 8'h61 && c <= 8'h66) d = {1'b0, 4'(c - 8'h57)};
    else if (c >= 8'h41 && c <= 8'h46) d = {1'b0, 4'(c - 8'h37)};
    return d;
  endfunction

  function automatic logic [7:0] hfcc_pair_value(input logic [7:0] first,
                                                 input logic [7:0] second);
    logic [4:0] hi;
    logic [4:0] lo;
    logic [7:0] v;
    hi = hfcc_hex_digit(first);
    lo = hfcc_hex_digit(second);
    if (hi[4])      v = 8'h00;
    else if (lo[4]) v = {4'h0, hi[3:0]};
    else            v = {hi[3:0], lo[3:0]};
    return v;
  endfunction

  function automatic logic [15:0] hfcc_crc_byte(input logic [15:0] crc_in,
                                                input logic [7:0]  b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) c = {c[14:0], 1'b0} ^ CRC_POLY;
      else       c = {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

/* rtl/hfcc_front.sv */
module hfcc_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                char_valid,
  input  hfcc_pkg::char_beat_t char_data,
  input  logic                q_full,
  output logic                char_stall,
  output logic                push,
  output hfcc_pkg::op_t       push_op
);
  import hfcc_pkg::*;

  logic [7:0] delay [DELAY_DEPTH];
  logic [3:0] char_count;
  logic       count_odd;
  logic       accept;

  assign char_stall = q_full;
  assign accept     = char_valid && !q_full;

  // A data pair closes four characters back on every odd character index.
  always_comb begin
    push_op.byte_ok     = (char_count >= 4'(DELAY_DEPTH)) && count_odd;
    push_op.byte_val    = hfcc_pair_value(delay[4], delay[3]);
    push_op.last        = char_data.last;
    push_op.short_frame = char_count < 4'(MIN_CHARS - 1);
    push_op.rx_crc      = {hfcc_pair_value(delay[2], delay[1]),
                           hfcc_pair_value(delay[0], char_data.character)};
    push                = accept && (push_op.byte_ok || char_data.last);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      char_count <= '0;
      count_odd  <= 1'b0;
      for (int i = 0; i < DELAY_DEPTH; i++) delay[i] <= '0;
    end else if (accept) begin
      if (char_data.last) begin
        char_count <= '0;
        count_odd  <= 1'b0;
        for (int i = 0; i < DELAY_DEPTH; i++) delay[i] <= '0;
      end else begin
        for (int i = DELAY_DEPTH - 1; i > 0; i--) delay[i] <= delay[i-1];
        delay[0]  <= char_data.character;
        if (char_count != COUNT_MAX) char_count <= char_count + 4'd1;
        count_odd <= ~count_odd;
      end
    end
  end

endmodule

/* rtl/hfcc_queue.sv */
module hfcc_queue #(
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  hfcc_pkg::op_t push_op,
  input  logic          pop,
  output logic          full,
  output logic          head_valid,
  output hfcc_pkg::op_t head_op
);
  import hfcc_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  op_t              slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full       = count == CNT_W'(DEPTH);
  assign head_valid = count != '0;
  assign head_op    = slots[rd_ptr];

  function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_op;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wrap_inc(wr_ptr);
      if (pop)  rd_ptr <= wrap_inc(rd_ptr);
      unique case ({push, pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

/* rtl/hfcc_back.sv */
module hfcc_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 head_valid,
  input  hfcc_pkg::op_t        head_op,
  input  logic                 res_stall,
  output logic                 pop,
  output logic                 res_valid,
  output hfcc_pkg::res_beat_t  res_data
);
  import hfcc_pkg::*;
  `include "assert_macros.svh"

  logic [15:0] crc;
  logic [15:0] crc_upd;
  logic [2:0]  bytes_taken;
  logic [7:0]  hdr      [HEADER_BYTES];
  logic [7:0]  hdr_next [HEADER_BYTES];
  logic        take_hdr;
  logic        pop_last;
  res_beat_t   result;

  // Hold a frame end while an earlier result still waits downstream.
  assign pop      = head_valid && (!head_op.last || !res_valid || !res_stall);
  assign pop_last = pop && head_op.last;
  assign take_hdr = head_op.byte_ok && (bytes_taken < 3'(HEADER_BYTES));

  always_comb begin
    crc_upd = head_op.byte_ok ? hfcc_crc_byte(crc, head_op.byte_val) : crc;
    for (int i = 0; i < HEADER_BYTES; i++) hdr_next[i] = hdr[i];
    if (take_hdr) hdr_next[bytes_taken] = head_op.byte_val;
    if (head_op.short_frame) begin
      result = '{status: STATUS_SHORT, frame_id: '0, sequence_res: '0,
                 payload_length: '0, received_crc: '0};
    end else begin
      result.status         = (head_op.rx_crc == crc_upd) ? STATUS_OK : STATUS_MISMATCH;
      result.frame_id       = hdr_next[0];
      result.sequence_res   = {hdr_next[1], hdr_next[2]};
      result.payload_length = {hdr_next[3], hdr_next[4]};
      result.received_crc   = head_op.rx_crc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc         <= CRC_INIT;
      bytes_taken <= '0;
      res_valid   <= 1'b0;
    end else begin
      if (res_valid && !res_stall) res_valid <= 1'b0;
      if (pop) begin
        if (head_op.last) begin
          res_valid   <= 1'b1;
          crc         <= CRC_INIT;
          bytes_taken <= '0;
        end else begin
          crc <= crc_upd;
          if (take_hdr) bytes_taken <= bytes_taken + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      for (int i = 0; i < HEADER_BYTES; i++) hdr[i] <= hdr_next[i];
    end
    if (pop_last) res_data <= result;
  end

  `HFCC_ASSERT(a_last_gives_result, clk, rst, pop_last |=> res_valid)
  `HFCC_ASSERT(a_no_overwrite, clk, rst, (res_valid && res_stall) |-> !pop_last)
  `HFCC_ASSERT(a_frame_clear, clk, rst, pop_last |=> (crc == CRC_INIT && bytes_taken == 3'd0))

endmodule

/* rtl/hex_frame_crc_checker_core.sv */
// Result path: the last character's op is written into the op queue, then popped by the back end
// into the registered result beat; it also waits behind every op queued ahead of it.
// Throughput: one character beat per cycle, set by the single-byte CRC step in the back end;
// a stalled result holds only frame ends, so bytes keep draining until the queue fills.
// Reset: synchronous, active high; clears the character history, CRC (to 0xFFFF) and queue.
module hex_frame_crc_checker_core #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 char_valid,
  output logic                 char_stall,
  input  hfcc_pkg::char_beat_t char_data,
  output logic                 res_valid,
  input  logic                 res_stall,
  output hfcc_pkg::res_beat_t  res_data
);
  import hfcc_pkg::*;

  // Front end: character history, pairing into bytes and frame-end
  // classification. Only beats that close a byte or end a frame become ops.
  logic q_full;
  logic push;
  op_t  push_op;

  // Queue between the halves, so the character side keeps moving while a
  // finished result waits to be taken.
  logic head_valid;
  op_t  head_op;
  logic pop;

  hfcc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .char_valid (char_valid),
    .char_data  (char_data),
    .q_full     (q_full),
    .char_stall (char_stall),
    .push       (push),
    .push_op    (push_op)
  );

  hfcc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_op    (push_op),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head_op    (head_op)
  );

  // Back end: running CRC, header capture and the registered result beat.
  hfcc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_op    (head_op),
    .res_stall  (res_stall),
    .pop        (pop),
    .res_valid  (res_valid),
    .res_data   (res_data)
  );

endmodule

/* tb/sv/tb_hex_frame_crc_checker_core.sv */
`timescale 1ns / 1ps

module tb_hex_frame_crc_checker_core;
  import hfcc_pkg::*;

  // Cycles with no beat moving on either side before the run is declared hung.
  localparam int STUCK_LIMIT  = 2000;
  // Length of the long result hold-off used to fill the block.
  localparam int HOLD_CYCLES  = 300;
  // Cycles to keep watching the result side once nothing is expected.
  localparam int TAIL_CYCLES  = 16;
  // Minimum number of characters sent in each random phase.
  localparam int PHASE_CHARS  = 125;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       char_valid = 1'b0;
  logic       char_stall;
  char_beat_t char_data = '0;
  logic       res_valid;
  logic       res_stall = 1'b0;
  res_beat_t  res_data;

  // Frame tracker: mirrors the block's character history, CRC and header bytes.
  logic [7:0]  hist [DELAY_DEPTH];
  logic [3:0]  seen;
  logic        odd_pos;
  logic [15:0] crc_acc;
  logic [2:0]  hdr_cnt;
  logic [7:0]  hdr [HEADER_BYTES];

  res_beat_t   pending_reports[$];
  logic [7:0]  frame_txt[$];

  int snd_pct = 0;
  int rcv_pct = 0;
  int hold_reqs = 0;
  int hold_done = 0;
  int hold_left = 0;
  int n_chars = 0;
  int n_frames = 0;
  int n_reports = 0;
  int n_errors = 0;
  int stuck_cycles = 0;

  hex_frame_crc_checker_core uut (
    .clk        (clk),
    .rst        (rst),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .char_data  (char_data),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .res_data   (res_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Frame tracker
  // ---------------------------------------------------------------------------

  // Hex digit value, or -1 when the character is not a digit.
  function automatic int digit_val(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c) - int'("0");
    if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
    if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
    return -1;
  endfunction

  // Value a character pair by its hex prefix: non-hex first gives zero,
  // non-hex second leaves the single first digit.
  function automatic logic [7:0] pair_byte(input logic [7:0] first, input logic [7:0] second);
    int hi;
    int lo;
    hi = digit_val(first);
    lo = digit_val(second);
    if (hi < 0) return 8'h00;
    if (lo < 0) return 8'(hi);
    return 8'(hi * 16 + lo);
  endfunction

  // CRC-16/CCITT-FALSE, one byte, MSB first, feedback form.
  function automatic logic [15:0] crc_step(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] r;
    logic        fb;
    r = acc;
    for (int k = 7; k >= 0; k--) begin
      fb = r[15] ^ b[k];
      r  = {r[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
    end
    return r;
  endfunction

  task automatic clear_frame();
    for (int i = 0; i < DELAY_DEPTH; i++) hist[i] = 8'h00;
    for (int i = 0; i < HEADER_BYTES; i++) hdr[i] = 8'h00;
    seen    = 4'd0;
    odd_pos = 1'b0;
    crc_acc = CRC_INIT;
    hdr_cnt = 3'd0;
  endtask

  // Advance the tracker by one accepted character; queue a report on the last one.
  task automatic track_char(input logic [7:0] c, input logic lst);
    logic [7:0]  b;
    logic [15:0] rx;
    res_beat_t   rep;
    // A data pair completes four characters back on every odd position.
    if (seen >= DELAY_DEPTH && odd_pos) begin
      b       = pair_byte(hist[4], hist[3]);
      crc_acc = crc_step(crc_acc, b);
      if (hdr_cnt < HEADER_BYTES) begin
        hdr[hdr_cnt] = b;
        hdr_cnt++;
      end
    end
    if (lst) begin
      rep = '0;
      if (int'(seen) + 1 < MIN_CHARS) begin
        // Too short: everything but the status stays zero.
        rep.status = STATUS_SHORT;
      end else begin
        rx                 = {pair_byte(hist[2], hist[1]), pair_byte(hist[0], c)};
        rep.status         = (rx == crc_acc) ? STATUS_OK : STATUS_MISMATCH;
        rep.frame_id       = hdr[0];
        rep.sequence_res   = {hdr[1], hdr[2]};
        rep.payload_length = {hdr[3], hdr[4]};
        rep.received_crc   = rx;
      end
      pending_reports.push_back(rep);
      n_frames++;
      clear_frame();
    end else begin
      for (int i = DELAY_DEPTH - 1; i > 0; i--) hist[i] = hist[i - 1];
      hist[0] = c;
      if (seen < COUNT_MAX) seen++;
      odd_pos = ~odd_pos;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Character side
  // ---------------------------------------------------------------------------

  // Offer one character beat, hold it until taken, then maybe go idle.
  task automatic send_char(input logic [7:0] c, input logic lst);
    char_data  <= '{character: c, last: lst};
    char_valid <= 1'b1;
    @(posedge clk);
    while (char_stall) @(posedge clk);
    track_char(c, lst);
    n_chars++;
    if ($urandom_range(99) < snd_pct) begin
      char_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < snd_pct);
    end
  endtask

  // Send the built frame text, marking its final character, then clear it.
  task automatic send_frame();
    foreach (frame_txt[i]) send_char(frame_txt[i], i == frame_txt.size() - 1);
    frame_txt.delete();
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    if (nib < 4'd10) return 8'("0") + 8'(nib);
    if ($urandom_range(1)) return 8'("A") + 8'(nib) - 8'd10;
    return 8'("a") + 8'(nib) - 8'd10;
  endfunction

  task automatic put_byte(input logic [7:0] b);
    frame_txt.push_back(hex_char(b[7:4]));
    frame_txt.push_back(hex_char(b[3:0]));
  endtask

  // Frame: n data bytes, optional stray digit, then the CRC text, corrupted when bad_crc is set.
  task automatic build_frame(input int n_data, input bit odd, input bit bad_crc);
    logic [7:0]  b;
    logic [15:0] crc;
    crc = CRC_INIT;
    for (int i = 0; i < n_data; i++) begin
      b = 8'($urandom);
      put_byte(b);
      crc = crc_step(crc, b);
    end
    if (odd) frame_txt.push_back(hex_char(4'($urandom)));
    if (bad_crc) crc ^= 16'($urandom_range(1, 16'hFFFF));
    put_byte(crc[15:8]);
    put_byte(crc[7:0]);
  endtask

  // Hex digits and arbitrary bytes, mixed at random.
  task automatic build_noise(input int len);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(1)) frame_txt.push_back(hex_char(4'($urandom)));
      else frame_txt.push_back(8'($urandom));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------------

  // Random stalls, or a long hold-off when one is requested.
  always @(posedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
    end else begin
      if (hold_reqs != hold_done) begin
        hold_done = hold_reqs;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        res_stall <= 1'b1;
        hold_left--;
      end else begin
        res_stall <= ($urandom_range(99) < rcv_pct);
      end
    end
  end

  task automatic flag_field(input string fld, input logic [15:0] want, input logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %h, actual %h", $time, fld, want, got);
      n_errors++;
    end
  endtask

  // Compare each accepted report beat with the oldest pending one.
  always @(posedge clk) begin
    res_beat_t want;
    if (!rst && res_valid && !res_stall) begin
      n_reports++;
      if (pending_reports.size() == 0) begin
        $display("%0t: report expected none, actual %h", $time, res_data);
        n_errors++;
      end else begin
        want = pending_reports.pop_front();
        flag_field("status", 16'(want.status), 16'(res_data.status));
        flag_field("frame_id", 16'(want.frame_id), 16'(res_data.frame_id));
        flag_field("sequence_res", want.sequence_res, res_data.sequence_res);
        flag_field("payload_length", want.payload_length, res_data.payload_length);
        flag_field("received_crc", want.received_crc, res_data.received_crc);
      end
    end
  end

  // Hang detector: count cycles in which no beat moves on either side.
  always @(posedge clk) begin
    if (!rst) begin
      if ((char_valid && !char_stall) || (res_valid && !res_stall)) stuck_cycles = 0;
      else stuck_cycles++;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("%0t: no beat moved for %0d cycles, %0d reports pending",
                 $time, STUCK_LIMIT, pending_reports.size());
        $display("simulation failed");
        $finish;
      end
    end
  end

  // Drop valid and wait until every pending report has been taken.
  task automatic wait_drain();
    char_valid <= 1'b0;
    do @(posedge clk); while (pending_reports.size() != 0);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Extreme header values, non-hex pairs, stray digit, bad CRC, tiny frames.
  task automatic test_corner_frames();
    snd_pct = 0;
    rcv_pct = 0;
    // All-ones header with a matching CRC: exactly 14 characters.
    build_frame(0, 1'b0, 1'b0);
    frame_txt.delete();
    begin
      logic [15:0] crc;
      crc = CRC_INIT;
      for (int i = 0; i < HEADER_BYTES; i++) begin
        put_byte(8'hFF);
        crc = crc_step(crc, 8'hFF);
      end
      put_byte(crc[15:8]);
      put_byte(crc[7:0]);
    end
    send_frame();
    // Non-hex first digit, hex then non-hex, zero bytes, stray digit, odd length.
    frame_txt = '{"G", "7", "7", "z", "0", "0", "0", "0", "0", "0", "5",
                  "f", "F", "f", "F"};
    send_frame();
    // Single marked character, then a two-character frame of extreme bytes.
    frame_txt = '{8'h00};
    send_frame();
    frame_txt = '{8'hFF, 8'hFF};
    send_frame();
    wait_drain();
  endtask

  // Mix of well-formed frames, short frames and noise at the current idle rates.
  task automatic run_random_frames(input int min_chars);
    int start;
    int pick;
    start = n_chars;
    while (n_chars - start < min_chars) begin
      pick = $urandom_range(99);
      if (pick < 65) build_frame($urandom_range(5, 12), 1'($urandom_range(1)),
                                 $urandom_range(7) == 0);
      else if (pick < 72) build_frame($urandom_range(13, 20), 1'($urandom_range(1)), 1'b0);
      else if (pick < 86) build_frame($urandom_range(0, 4), 1'($urandom_range(1)), 1'b0);
      else build_noise($urandom_range(1, 30));
      send_frame();
    end
    wait_drain();
  endtask

  task automatic test_streaming();
    snd_pct = 0;
    rcv_pct = 0;
    run_random_frames(PHASE_CHARS);
  endtask

  task automatic test_sender_gaps();
    snd_pct = 72;
    rcv_pct = 0;
    run_random_frames(PHASE_CHARS);
  endtask

  task automatic test_receiver_stalls();
    snd_pct = 0;
    rcv_pct = 72;
    run_random_frames(PHASE_CHARS);
  endtask

  task automatic test_mixed_gaps();
    snd_pct = 35;
    rcv_pct = 35;
    run_random_frames(PHASE_CHARS);
  endtask

  // Hold the result side off while short frames keep coming, so reports pile
  // up, the op queue fills and the character side stalls.
  task automatic test_queue_backpressure();
    snd_pct = 0;
    rcv_pct = 0;
    hold_reqs++;
    for (int f = 0; f < 12; f++) begin
      build_noise($urandom_range(1, 3));
      send_frame();
    end
    build_frame(6, 1'b0, 1'b0);
    send_frame();
    wait_drain();
  endtask

  initial begin
    clear_frame();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_corner_frames();
    test_streaming();
    test_sender_gaps();
    test_receiver_stalls();
    test_mixed_gaps();
    test_queue_backpressure();

    // Watch for stray reports after everything has been answered.
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Checked %0d frames (%0d characters, %0d reports) across idle, gap, stall",
             n_frames, n_chars, n_reports);
    $display("and long hold-off phases; %0d field mismatches.", n_errors);
    if (n_errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
